// ===== hw/rtl/fca_pkg.sv =====
`default_nettype none

package fca_pkg;

    localparam int PTR_W = 13;
    localparam int OUT_W = 13;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [1:0] {
        ST_UNVISITED = 2'd0,
        ST_ON_PATH   = 2'd1,
        ST_RESOLVED  = 2'd2,
        ST_CYCLE     = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_RD      = 7'b0000100,
        S_EV      = 7'b0001000,
        S_POP     = 7'b0010000,
        S_POP_EV  = 7'b0100000,
        S_SPARE   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/fca_ram.sv =====
`default_nettype none

module fca_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fat_chain_analyzer_core.sv =====
// Block allocation table chain analyzer.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. Each transaction loads one table entry (i_next_block, -1 or any
// negative value or an index at or beyond the loaded count ends a chain).
// Loading runs at one entry per cycle. Entries past TABLE_DEPTH are dropped
// and reported through o_table_overflow.
// The transaction with i_last_entry high closes the table. busy then rises
// and the block walks every chain through the table memory and a path stack
// memory, visiting table entries and then popping the stack. The result is
// then shown for one cycle with o_result_valid and busy falls at that edge.
// The receiver cannot stall, so the result must be taken in that cycle.
// Counts saturate at 8191. After the result the table is empty again.
// Reset is synchronous and active low; it empties the table and clears the
// internal overflow flag, but not o_table_overflow. Memory contents need no
// clearing: every entry is rewritten with its status during load before the walk reads it.
`default_nettype none

module fat_chain_analyzer_core #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [fca_pkg::PTR_W-1:0] i_next_block,
    input  wire logic                      i_last_entry,
    output logic                           o_result_valid,
    output logic [fca_pkg::OUT_W-1:0]      o_longest_chain,
    output logic [fca_pkg::OUT_W-1:0]      o_blocks_in_cycles,
    output logic                           o_table_overflow
);

    import fca_pkg::*;

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int LW   = $clog2(TABLE_DEPTH + 2);
    localparam int DW   = PTR_W + 2 + LW;
    localparam int SW   = (LW > OUT_W) ? LW : OUT_W;
    localparam int CMPW = (CW > PTR_W) ? CW : PTR_W;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CW-1:0]   r_start, n_start;
    logic [AW-1:0]   r_node, n_node;
    logic [CW-1:0]   r_sp, n_sp;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_cyc, n_cyc;
    logic [LW-1:0]   r_best, n_best;
    logic            r_into, n_into;
    logic            r_valid, n_valid;
    logic [OUT_W-1:0] r_longest, n_longest;
    logic [OUT_W-1:0] r_cycles, n_cycles;
    logic            r_out_ovf, n_out_ovf;

    logic            tbl_we;
    logic [AW-1:0]   tbl_waddr;
    logic [DW-1:0]   tbl_wdata;
    logic [DW-1:0]   tbl_rdata;
    logic            stk_we;
    logic [AW-1:0]   stk_waddr;
    logic [AW-1:0]   stk_wdata;
    logic [AW-1:0]   stk_raddr;
    logic [AW-1:0]   stk_rdata;

    logic [PTR_W-1:0] rd_ptr;
    t_status          rd_status;
    logic [LW-1:0]    rd_len;
    logic [CMPW-1:0]  raw_ext;
    logic [CMPW-1:0]  count_ext;
    logic [SW-1:0]    best_ext;
    logic [SW-1:0]    cyc_ext;
    logic             full;

    fca_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_node),
        .o_rdata (tbl_rdata)
    );

    fca_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign rd_ptr    = tbl_rdata[DW-1 -: PTR_W];
    assign rd_status = t_status'(tbl_rdata[LW +: 2]);
    assign rd_len    = tbl_rdata[LW-1:0];
    assign raw_ext   = CMPW'(rd_ptr[PTR_W-2:0]);
    assign count_ext = CMPW'(r_count);
    assign best_ext  = SW'(r_best);
    assign cyc_ext   = SW'(r_cyc);
    assign full      = (r_count == CW'(TABLE_DEPTH));
    assign stk_raddr = AW'(r_sp - CW'(1));

    assign busy               = (r_state != S_IDLE);
    assign o_result_valid     = r_valid;
    assign o_longest_chain    = r_longest;
    assign o_blocks_in_cycles = r_cycles;
    assign o_table_overflow   = r_out_ovf;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_start   = r_start;
        n_node    = r_node;
        n_sp      = r_sp;
        n_len     = r_len;
        n_cyc     = r_cyc;
        n_best    = r_best;
        n_into    = r_into;
        n_valid   = 1'b0;
        n_longest = r_longest;
        n_cycles  = r_cycles;
        n_out_ovf = r_out_ovf;
        tbl_we    = 1'b0;
        tbl_waddr = r_node;
        tbl_wdata = {PTR_W'(0), ST_ON_PATH, LW'(0)};
        stk_we    = 1'b0;
        stk_waddr = r_sp[AW-1:0];
        stk_wdata = r_node;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!full) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = r_count[AW-1:0];
                        tbl_wdata = {i_next_block, ST_UNVISITED, LW'(0)};
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_entry) begin
                        n_start = '0;
                        n_best  = '0;
                        n_cyc   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_start == r_count) begin
                    n_valid   = 1'b1;
                    n_longest = (best_ext > SW'(OUT_MAX)) ? OUT_MAX : best_ext[OUT_W-1:0];
                    n_cycles  = (cyc_ext > SW'(OUT_MAX)) ? OUT_MAX : cyc_ext[OUT_W-1:0];
                    n_out_ovf = r_ovf;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_node  = r_start[AW-1:0];
                    n_sp    = '0;
                    n_len   = LW'(1);
                    n_into  = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (rd_status != ST_UNVISITED) begin
                    if (rd_status == ST_RESOLVED) begin
                        n_len = rd_len + LW'(1);
                    end else begin
                        n_into = 1'b1;
                    end
                    n_state = S_POP;
                end else begin
                    tbl_we  = 1'b1;
                    stk_we  = 1'b1;
                    n_sp    = r_sp + CW'(1);
                    if (rd_ptr[PTR_W-1] || (raw_ext >= count_ext)) begin
                        n_state = S_POP;
                    end else begin
                        n_node  = raw_ext[AW-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_start = r_start + CW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_sp    = r_sp - CW'(1);
                    n_state = S_POP_EV;
                end
            end
            S_POP_EV: begin
                tbl_we    = 1'b1;
                tbl_waddr = stk_rdata;
                if (r_into) begin
                    tbl_wdata = {PTR_W'(0), ST_CYCLE, LW'(0)};
                    n_cyc     = r_cyc + LW'(1);
                end else begin
                    tbl_wdata = {PTR_W'(0), ST_RESOLVED, r_len};
                    if (r_len > r_best) begin
                        n_best = r_len;
                    end
                    n_len = r_len + LW'(1);
                end
                n_state = S_POP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start   <= n_start;
        r_node    <= n_node;
        r_len     <= n_len;
        r_cyc     <= n_cyc;
        r_best    <= n_best;
        r_into    <= n_into;
        r_longest <= n_longest;
        r_cycles  <= n_cycles;
        r_out_ovf <= n_out_ovf;
    end

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("Result strobe lasted more than one cycle.");

    a_result_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(busy) && !busy && r_count == '0))
        else $error("Result shown without a finished walk.");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_count)
        else $error("Path stack deeper than the loaded table.");

    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_sp == '0))
        else $error("Path stack not empty while idle.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("Entry count beyond table depth.");
`endif

endmodule

`default_nettype wire
